// ===== hw/rtl/twv_pkg.sv =====
// shared constants, types and the arctangent table for the true wind vector block
// no dependencies; used by every rtl file in this folder
package twv_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int SPEED_BITS    = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int TABLE_LEN = 32;
    localparam int NSTAGES   = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int STAGE_W   = $clog2(TABLE_LEN);

    // guard bits below the speed lsb inside the cordic datapath
    localparam int GUARD = 8;
    // component width: start value below 2^(SPEED_BITS+8), gains and the subtraction add < 3 bits
    localparam int VW    = SPEED_BITS + 12;
    // rotation angle accumulator, signed with headroom over one turn
    localparam int ZW    = 34;

    localparam logic [29:0] KQ30    = 30'd652032874;
    localparam logic [19:0] KQ20    = 20'd636751;
    localparam int          X0_SH   = 22;
    localparam int          X0_W    = SPEED_BITS + 30 - X0_SH;
    localparam int          MAG_SH  = GUARD + 20;
    localparam int          PROD_W  = VW + 20;
    localparam int          MAG_W   = PROD_W - MAG_SH;
    localparam int          OSPD_W  = SPEED_BITS + 1;
    localparam int          ANG_SH  = 32 - ANGLE_BITS;

    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    // field packing of the streams
    localparam int IN_DATA_W  = ((2 * SPEED_BITS + 2 * ANGLE_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_W  = OSPD_W + ANGLE_BITS;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_rvec;

    // apparent wind and vessel motion rotate side by side
    typedef struct packed {
        t_rvec a;
        t_rvec b;
    } t_rot;

    typedef struct packed {
        logic                 zero;
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic [31:0]          z;
    } t_vec;

endpackage

// ===== hw/rtl/twv_rot_cell.sv =====
// one cordic rotation step for both polar pairs, with its own pipeline register
// depends on twv_pkg
module twv_rot_cell
    import twv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [STAGE_W-1:0] i_stage,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_rot               i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output t_rot               o_data
);

    logic  r_valid;
    t_rot  r_data;
    t_rot  n_data;
    logic signed [ZW-1:0] w_atan;

    assign w_atan = signed'({{(ZW-32){1'b0}}, ATAN_TURNS[i_stage]});

    function automatic t_rvec rot_step(input t_rvec v, input logic [STAGE_W-1:0] k,
                                       input logic signed [ZW-1:0] t);
        t_rvec                r;
        logic signed [VW-1:0] dx;
        logic signed [VW-1:0] dy;
        dx = v.y >>> k;
        dy = v.x >>> k;
        if (v.z >= 0) begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - t;
        end else begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + t;
        end
        return r;
    endfunction

    always_comb begin
        n_data.a = rot_step(i_data.a, i_stage, w_atan);
        n_data.b = rot_step(i_data.b, i_stage, w_atan);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/twv_vec_cell.sv =====
// one cordic vectoring step on the difference vector, with its own pipeline register
// depends on twv_pkg
module twv_vec_cell
    import twv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [STAGE_W-1:0] i_stage,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_vec               i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output t_vec               o_data
);

    logic                 r_valid;
    t_vec                 r_data;
    t_vec                 n_data;
    logic signed [VW-1:0] w_dx;
    logic signed [VW-1:0] w_dy;

    assign w_dx = i_data.y >>> i_stage;
    assign w_dy = i_data.x >>> i_stage;

    always_comb begin
        n_data.zero = i_data.zero;
        if (i_data.y > 0) begin
            n_data.x = i_data.x + w_dx;
            n_data.y = i_data.y - w_dy;
            n_data.z = i_data.z + ATAN_TURNS[i_stage];
        end else begin
            n_data.x = i_data.x - w_dx;
            n_data.y = i_data.y + w_dy;
            n_data.z = i_data.z - ATAN_TURNS[i_stage];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/true_wind_vector.sv =====
// top level of the true wind vector block: input scaling, rotation chain,
// subtraction, vectoring chain, magnitude scaling and output register
// depends on twv_pkg, twv_rot_cell and twv_vec_cell
//
// usage:
//   s_axis carries one item per sample set: apparent wind speed and direction,
//   vessel speed and heading. m_axis returns one item per input item, in order:
//   the true wind speed (q9.8) and direction (binary angle, zero vector gives 0).
//   the pipeline registers, in order, are one scaling multiply, NSTAGES rotation
//   cells, the subtraction, NSTAGES vectoring cells, the magnitude multiply and
//   the output register.
//   throughput is one item per cycle while m_axis_tready stays high; every cell
//   holds one item in flight and the chain of cells sets the latency.
//   each stage hands its item on when the next stage is empty or moving, so a
//   stall on m_axis_tready fills the empty stages first; s_axis_tready drops
//   only when every stage holds an item.
//   reset clears all stage valid flags; items in flight are dropped and no
//   configuration exists.
module true_wind_vector
    import twv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // apparent_speed, apparent_angle, vessel_speed, vessel_heading
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // true_speed, true_angle, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int AS_LO = 0;
    localparam int AA_LO = AS_LO + SPEED_BITS;
    localparam int VS_LO = AA_LO + ANGLE_BITS;
    localparam int VH_LO = VS_LO + SPEED_BITS;
    localparam logic [X0_SH+X0_W-1:0] X0_RND  = (X0_SH+X0_W)'(1) << (X0_SH - 1);
    localparam logic [PROD_W-1:0]     MAG_RND = PROD_W'(1) << (MAG_SH - 1);
    localparam logic [MAG_W-1:0]      SPD_MAX = MAG_W'({OSPD_W{1'b1}});
    localparam logic [32:0]           ANG_RND = (33'd1 << ANG_SH) >> 1;

    // polar to start vector for one pair
    function automatic t_rvec pre_rot(input logic [SPEED_BITS-1:0] r,
                                      input logic [ANGLE_BITS-1:0] ang);
        t_rvec                     v;
        logic [X0_SH+X0_W-1:0]     prod;
        logic signed [VW-1:0]      x0;
        logic [31:0]               a;
        prod = (X0_SH+X0_W)'(r) * (X0_SH+X0_W)'(KQ30) + X0_RND;
        x0   = signed'(VW'(prod[X0_SH +: X0_W]));
        a    = 32'(ang) << ANG_SH;
        // second and third quadrant start from the mirrored vector
        if (a[31] ^ a[30]) begin
            x0 = -x0;
            a  = a - HALF_TURN;
        end
        v.x = x0;
        v.y = '0;
        v.z = signed'({{(ZW-32){a[31]}}, a});
        return v;
    endfunction

    // ---------------- input scaling stage
    logic r_pre_v;
    t_rot r_pre;
    logic w_pre_rdy;

    logic [NSTAGES:0] w_rot_v;
    logic [NSTAGES:0] w_rot_rdy;
    t_rot             w_rot_d [NSTAGES+1];

    assign w_pre_rdy     = !r_pre_v || w_rot_rdy[0];
    assign s_axis_tready = w_pre_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_v <= 1'b0;
        end else if (w_pre_rdy) begin
            r_pre_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pre_rdy && s_axis_tvalid) begin
            r_pre.a <= pre_rot(s_axis_tdata[AS_LO +: SPEED_BITS],
                               s_axis_tdata[AA_LO +: ANGLE_BITS]);
            r_pre.b <= pre_rot(s_axis_tdata[VS_LO +: SPEED_BITS],
                               s_axis_tdata[VH_LO +: ANGLE_BITS]);
        end
    end

    // ---------------- rotation chain
    assign w_rot_v[0] = r_pre_v;
    assign w_rot_d[0] = r_pre;

    for (genvar k = 0; k < NSTAGES; k++) begin : g_rot
        twv_rot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (STAGE_W'(k)),
            .i_valid (w_rot_v[k]),
            .o_ready (w_rot_rdy[k]),
            .i_data  (w_rot_d[k]),
            .o_valid (w_rot_v[k+1]),
            .i_ready (w_rot_rdy[k+1]),
            .o_data  (w_rot_d[k+1])
        );
    end

    // ---------------- subtraction and vectoring start
    logic                 r_dif_v;
    t_vec                 r_dif;
    t_vec                 n_dif;
    logic signed [VW-1:0] w_dx;
    logic signed [VW-1:0] w_dy;

    logic [NSTAGES:0] w_vec_v;
    logic [NSTAGES:0] w_vec_rdy;
    t_vec             w_vec_d [NSTAGES+1];

    assign w_rot_rdy[NSTAGES] = !r_dif_v || w_vec_rdy[0];
    assign w_dx = w_rot_d[NSTAGES].a.x - w_rot_d[NSTAGES].b.x;
    assign w_dy = w_rot_d[NSTAGES].a.y - w_rot_d[NSTAGES].b.y;

    always_comb begin
        n_dif.zero = (w_dx == '0) && (w_dy == '0);
        if (w_dx < 0) begin
            n_dif.x = -w_dx;
            n_dif.y = -w_dy;
            n_dif.z = HALF_TURN;
        end else begin
            n_dif.x = w_dx;
            n_dif.y = w_dy;
            n_dif.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dif_v <= 1'b0;
        end else if (w_rot_rdy[NSTAGES]) begin
            r_dif_v <= w_rot_v[NSTAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rot_rdy[NSTAGES] && w_rot_v[NSTAGES]) begin
            r_dif <= n_dif;
        end
    end

    // ---------------- vectoring chain
    assign w_vec_v[0] = r_dif_v;
    assign w_vec_d[0] = r_dif;

    for (genvar k = 0; k < NSTAGES; k++) begin : g_vec
        twv_vec_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (STAGE_W'(k)),
            .i_valid (w_vec_v[k]),
            .o_ready (w_vec_rdy[k]),
            .i_data  (w_vec_d[k]),
            .o_valid (w_vec_v[k+1]),
            .i_ready (w_vec_rdy[k+1]),
            .o_data  (w_vec_d[k+1])
        );
    end

    // ---------------- magnitude multiply
    logic              r_mag_v;
    logic [PROD_W-1:0] r_mag_prod;
    logic              r_mag_zero;
    logic [31:0]       r_mag_z;
    logic              w_mag_rdy;
    logic              w_out_rdy;

    assign w_mag_rdy          = !r_mag_v || w_out_rdy;
    assign w_vec_rdy[NSTAGES] = w_mag_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_v <= 1'b0;
        end else if (w_mag_rdy) begin
            r_mag_v <= w_vec_v[NSTAGES];
        end
    end

    // x is never negative after vectoring
    always_ff @(posedge i_clk) begin
        if (w_mag_rdy && w_vec_v[NSTAGES]) begin
            r_mag_prod <= PROD_W'($unsigned(w_vec_d[NSTAGES].x)) * PROD_W'(KQ20);
            r_mag_zero <= w_vec_d[NSTAGES].zero;
            r_mag_z    <= w_vec_d[NSTAGES].z;
        end
    end

    // ---------------- rounding, saturation and output register
    logic                  r_out_v;
    logic [OSPD_W-1:0]     r_speed;
    logic [ANGLE_BITS-1:0] r_angle;
    logic [OSPD_W-1:0]     n_speed;
    logic [ANGLE_BITS-1:0] n_angle;
    logic [PROD_W-1:0]     w_mag_sum;
    logic [MAG_W-1:0]      w_mag;
    logic [32:0]           w_ang_sum;

    assign w_out_rdy = !r_out_v || m_axis_tready;
    assign w_mag_sum = r_mag_prod + MAG_RND;
    assign w_mag     = w_mag_sum[MAG_SH +: MAG_W];
    assign w_ang_sum = {1'b0, r_mag_z} + ANG_RND;

    always_comb begin
        if (r_mag_zero) begin
            n_speed = '0;
            n_angle = '0;
        end else begin
            n_speed = (w_mag > SPD_MAX) ? SPD_MAX[OSPD_W-1:0] : w_mag[OSPD_W-1:0];
            n_angle = w_ang_sum[ANG_SH +: ANGLE_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_rdy) begin
            r_out_v <= r_mag_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy && r_mag_v) begin
            r_speed <= n_speed;
            r_angle <= n_angle;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {{(OUT_DATA_W-OUT_RAW_W){1'b0}}, r_angle, r_speed};

endmodule

// ===== verif/true_wind_vector_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for true_wind_vector: directed table then random sample sets
// depends on twv_pkg and the true_wind_vector rtl; predicts each item without a fixed result with its own cordic
module true_wind_vector_tb;
    import twv_pkg::*;

    localparam int RUN_LIMIT    = 600000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 2 * CORDIC_STAGES + 40;
    localparam int CHUNKS       = 21;
    localparam int CHUNK_ITEMS  = 50;

    localparam int ROT_STAGES = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int ANG_SHIFT  = 32 - ANGLE_BITS;
    localparam longint unsigned GAIN_Q30 = 64'd652032874;
    localparam longint unsigned GAIN_Q20 = 64'd636751;

    // atan(2^-i) in 2^-32 turn units
    localparam longint ARCTAN [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    typedef struct packed {
        logic [OSPD_W-1:0]     speed;
        logic [ANGLE_BITS-1:0] angle;
    } t_wind_result;

    typedef struct {
        logic [IN_DATA_W-1:0] data;
        bit                   fixed;
        t_wind_result         want;
    } t_offer;

    typedef struct packed {
        logic [SPEED_BITS-1:0] app_speed;
        logic [ANGLE_BITS-1:0] app_angle;
        logic [SPEED_BITS-1:0] ves_speed;
        logic [ANGLE_BITS-1:0] ves_heading;
        logic                  fixed;
        logic [OSPD_W-1:0]     want_speed;
        logic [ANGLE_BITS-1:0] want_angle;
    } t_row;

    typedef enum logic [1:0] {RX_RANDOM, RX_STEADY, RX_HOLD} t_rx_mode;

    // zero-vector rows carry their result; the rest go through the predictor
    localparam t_row DIRECTED [22] = '{
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 17'd0, 16'd0},
        '{16'hFFFF, 16'h1234, 16'hFFFF, 16'h1234, 1'b1, 17'd0, 16'd0},
        '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 17'd0, 16'd0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 17'd0, 16'd0},
        '{16'h8000, 16'h4000, 16'h8000, 16'h4000, 1'b1, 17'd0, 16'd0},
        '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000, 1'b0, 17'd0, 16'd0},
        '{16'hFFFF, 16'h4000, 16'h0000, 16'h0000, 1'b0, 17'd0, 16'd0},
        '{16'hFFFF, 16'h8000, 16'h0000, 16'h0000, 1'b0, 17'd0, 16'd0},
        '{16'hFFFF, 16'hC000, 16'h0000, 16'h0000, 1'b0, 17'd0, 16'd0},
        '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 17'd0, 16'd0},
        '{16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b0, 17'd0, 16'd0},
        '{16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 17'd0, 16'd0},
        '{16'h0000, 16'h0000, 16'hFFFF, 16'h7FFF, 1'b0, 17'd0, 16'd0},
        '{16'h1000, 16'h3FFF, 16'h0000, 16'h0000, 1'b0, 17'd0, 16'd0},
        '{16'h1000, 16'hBFFF, 16'h0000, 16'h0000, 1'b0, 17'd0, 16'd0},
        '{16'h1000, 16'h7FFF, 16'h1000, 16'hC000, 1'b0, 17'd0, 16'd0},
        '{16'h8000, 16'h2000, 16'h8000, 16'h6000, 1'b0, 17'd0, 16'd0},
        '{16'h0100, 16'h0000, 16'h00FF, 16'h0000, 1'b0, 17'd0, 16'd0},
        '{16'h0001, 16'h8000, 16'h0001, 16'h0000, 1'b0, 17'd0, 16'd0},
        '{16'h0A00, 16'h1000, 16'h0A00, 16'h1001, 1'b0, 17'd0, 16'd0},
        '{16'hFFFF, 16'h4000, 16'hFFFF, 16'hC000, 1'b0, 17'd0, 16'd0},
        '{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b0, 17'd0, 16'd0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // apparent_speed, apparent_angle, vessel_speed, vessel_heading
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // true_speed, true_angle, zero fill
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    t_offer       offered_items [$];
    t_wind_result wind_expected [$];
    t_offer       accepted_row;
    t_wind_result oldest;
    t_wind_result got;
    t_rx_mode     rx_mode = RX_RANDOM;
    bit           tx_steady = 1'b0;
    int unsigned  cycle_count = 0;
    int           mismatches = 0;

    true_wind_vector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // polar to cartesian by cordic rotation, components in speed units * 2^8
    function automatic void to_components(input logic [SPEED_BITS-1:0] r,
                                          input logic [ANGLE_BITS-1:0] ang,
                                          output longint x, output longint y);
        longint      dx, dy, z;
        logic [31:0] turns;
        int          i;
        x = longint'((64'(r) * GAIN_Q30 + 64'd2097152) >> 22);
        y = 0;
        turns = 32'(64'(ang) << ANG_SHIFT);
        // second and third quadrants start from the mirrored vector
        if (turns[31:30] == 2'b01 || turns[31:30] == 2'b10) begin
            x = -x;
            turns = turns - 32'h8000_0000;
        end
        z = longint'(signed'(turns));
        for (i = 0; i < ROT_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN[i];
            end
        end
    endfunction

    function automatic t_wind_result predict_true_wind(input logic [IN_DATA_W-1:0] d);
        t_wind_result     res;
        longint           ax, ay, bx, by, x, y, z, dx, dy;
        longint unsigned  mag, ang;
        int               i;
        to_components(d[SPEED_BITS-1:0], d[SPEED_BITS+ANGLE_BITS-1:SPEED_BITS], ax, ay);
        to_components(d[2*SPEED_BITS+ANGLE_BITS-1:SPEED_BITS+ANGLE_BITS],
                      d[2*SPEED_BITS+2*ANGLE_BITS-1:2*SPEED_BITS+ANGLE_BITS], bx, by);
        x = ax - bx;
        y = ay - by;
        if (x == 0 && y == 0) begin
            res.speed = '0;
            res.angle = '0;
            return res;
        end
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 64'sd2147483648;
        end
        for (i = 0; i < ROT_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN[i];
            end
        end
        mag = ($unsigned(x) * GAIN_Q20 + 64'd134217728) >> 28;
        if (mag > (64'd1 << OSPD_W) - 1)
            mag = (64'd1 << OSPD_W) - 1;
        ang = $unsigned(z) & 64'hFFFF_FFFF;
        if (ANG_SHIFT > 0)
            ang = (ang + (64'd1 << (ANG_SHIFT - 1))) >> ANG_SHIFT;
        res.speed = mag[OSPD_W-1:0];
        res.angle = ang[ANGLE_BITS-1:0];
        return res;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_sample(input logic [SPEED_BITS-1:0] as,
                                                         input logic [ANGLE_BITS-1:0] aa,
                                                         input logic [SPEED_BITS-1:0] vs,
                                                         input logic [ANGLE_BITS-1:0] vh);
        return IN_DATA_W'({vh, vs, aa, as});
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_sample();
        logic [SPEED_BITS-1:0] as, vs;
        logic [ANGLE_BITS-1:0] aa, vh;
        as = SPEED_BITS'($urandom);
        aa = ANGLE_BITS'($urandom);
        vs = SPEED_BITS'($urandom);
        vh = ANGLE_BITS'($urandom);
        case ($urandom_range(0, 9))
            5: begin
                as = SPEED_BITS'($urandom_range(0, 511));
                vs = SPEED_BITS'($urandom_range(0, 511));
            end
            6: begin
                // same vector twice cancels to nothing
                vs = as;
                vh = aa;
            end
            7: begin
                vs = as;
                vh = aa + ANGLE_BITS'($urandom_range(1, 3));
            end
            8: if ($urandom_range(0, 1)) as = '0; else vs = '0;
            9: begin
                as[SPEED_BITS-1:SPEED_BITS-8] = '1;
                vs[SPEED_BITS-1:SPEED_BITS-8] = '1;
            end
            default: ;
        endcase
        return pack_sample(as, aa, vs, vh);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 90) return $urandom_range(3, 8);
        if (r < 98) return $urandom_range(9, 30);
        return $urandom_range(40, 100);
    endfunction

    task automatic report_mismatch(input string what, input longint gotv, input longint wantv);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, gotv,
                     wantv);
    endtask

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic offer_item(input logic [IN_DATA_W-1:0] d, input bit fixed,
                              input t_wind_result want);
        int     gap;
        t_offer o;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        o.data = d;
        o.fixed = fixed;
        o.want = want;
        offered_items.push_back(o);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = d;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (wind_expected.size() != 0 || offered_items.size() != 0)
            @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                accepted_row = offered_items.pop_front();
                wind_expected.push_back(accepted_row.fixed ? accepted_row.want
                                        : predict_true_wind(accepted_row.data));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.speed = m_axis_tdata[OSPD_W-1:0];
                got.angle = m_axis_tdata[OSPD_W+ANGLE_BITS-1:OSPD_W];
                if (wind_expected.size() == 0) begin
                    report_mismatch("unexpected item, speed", longint'(got.speed),
                                    longint'(0));
                end else begin
                    oldest = wind_expected.pop_front();
                    if (got.speed !== oldest.speed)
                        report_mismatch("true_speed", longint'(got.speed),
                                        longint'(oldest.speed));
                    if (got.angle !== oldest.angle)
                        report_mismatch("true_angle", longint'(got.angle),
                                        longint'(oldest.angle));
                end
            end
        end
    end

    // result side: random stalls, steady stretches, and one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_mode == RX_HOLD) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                rx_mode = RX_RANDOM;
                m_axis_tready = 1'b1;
            end else if (rx_mode == RX_STEADY) begin
                m_axis_tready = 1'b1;
            end else begin
                m_axis_tready = ($urandom_range(0, 3) != 0);
                repeat (stall_len() - 1) @(negedge i_clk);
            end
        end
    end

    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int           chunk, n, pick;
        t_wind_result want;
        t_wind_result none;
        none.speed = '0;
        none.angle = '0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED[k]) begin
            want.speed = DIRECTED[k].want_speed;
            want.angle = DIRECTED[k].want_angle;
            offer_item(pack_sample(DIRECTED[k].app_speed, DIRECTED[k].app_angle,
                                   DIRECTED[k].ves_speed, DIRECTED[k].ves_heading),
                       DIRECTED[k].fixed, want);
        end
        s_axis_tvalid = 1'b0;
        wait_drained();

        for (chunk = 0; chunk < CHUNKS; chunk++) begin
            pick = $urandom_range(0, 5);
            if (chunk == 1) pick = 0;
            if (chunk == 2 || chunk == 12) pick = 1;
            if (chunk % 7 == 5) begin
                // sender pauses until the pipeline is empty
                s_axis_tvalid = 1'b0;
                wait_drained();
            end
            if (pick == 0) begin
                tx_steady = 1'b1;
                rx_mode = RX_STEADY;
            end else if (pick == 1) begin
                // keep offering while the result side holds off, so the pipe fills
                tx_steady = 1'b1;
                rx_mode = RX_HOLD;
            end else begin
                tx_steady = 1'b0;
                rx_mode = RX_RANDOM;
            end
            for (n = 0; n < CHUNK_ITEMS; n++)
                offer_item(random_sample(), 1'b0, none);
        end
        s_axis_tvalid = 1'b0;
        tx_steady = 1'b0;
        rx_mode = RX_RANDOM;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (wind_expected.size() != 0)
            report_mismatch("results missing", longint'(wind_expected.size()), longint'(0));
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
